// File: src/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types, codes and helpers for the EDF tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package eds_pkg;

	localparam int SLOT_W = 3;
	localparam int VAL_W  = 16;
	localparam int TIME_W = 32;
	localparam int MASK_W = 8;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_LOAD = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// one task entry as seen by the shared unit
	typedef struct packed {
		logic              valid;
		logic [VAL_W-1:0]  budget;
		logic [VAL_W-1:0]  period;
		logic [VAL_W-1:0]  work;
		logic [TIME_W-1:0] release_t;
		logic [TIME_W-1:0] due;
	} entry_t;

	// shared unit result
	typedef struct packed {
		logic              rel_hit;
		logic              miss;
		logic              take;
		logic [TIME_W-1:0] new_due;
	} unit_res_t;

	// sequencer controls
	typedef struct packed {
		logic in_ready;
		logic scan;
		logic emit;
	} ctl_t;

	function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
		return (&v) ? v : v + TIME_W'(1);
	endfunction

endpackage

`default_nettype wire

// File: src/eds_if.sv
// ----------------------------------------------------------------------------
// eds_if
// Request and response channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface eds_req_if;
	import eds_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [SLOT_W-1:0] task_slot;
	logic [VAL_W-1:0]  task_budget;
	logic [VAL_W-1:0]  task_period;
	logic [VAL_W-1:0]  task_offset;

	modport source (output valid, action, task_slot, task_budget, task_period,
		task_offset, input ready);
	modport sink (input valid, action, task_slot, task_budget, task_period,
		task_offset, output ready);
endinterface

interface eds_rsp_if;
	import eds_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] running_task;
	logic              cpu_idle;
	logic [MASK_W-1:0] miss_mask;
	logic [TIME_W-1:0] tick_time;
	logic [TIME_W-1:0] busy_ticks;
	logic [TIME_W-1:0] miss_count;

	modport source (output valid, running_task, cpu_idle, miss_mask, tick_time,
		busy_ticks, miss_count, input ready);
	modport sink (input valid, running_task, cpu_idle, miss_mask, tick_time,
		busy_ticks, miss_count, output ready);
endinterface

`default_nettype wire

// File: src/eds_unit.sv
// ----------------------------------------------------------------------------
// eds_unit
// Shared release/select unit: one task entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_unit (
	input  eds_pkg::entry_t              ent,
	input  logic [eds_pkg::TIME_W-1:0]   time_now,
	input  logic                         found,
	input  logic [eds_pkg::TIME_W-1:0]   best,
	output eds_pkg::unit_res_t           res
);
	import eds_pkg::*;

	logic [VAL_W-1:0]  new_work;
	logic [TIME_W-1:0] sum;

	assign sum = ent.release_t + TIME_W'(ent.period);

	always_comb begin
		res.rel_hit = ent.valid && (ent.release_t == time_now);
		res.miss    = res.rel_hit && (ent.work != '0);
		new_work    = res.rel_hit ? ent.budget : ent.work;
		res.new_due = res.rel_hit ? sum : ent.due;
		res.take    = ent.valid && (new_work != '0) && (!found || (res.new_due < best));
	end

endmodule

`default_nettype wire

// File: src/earliest_deadline_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// earliest_deadline_tick_scheduler_top
// Periodic-task EDF scheduler stepped by tick transactions.
//
//  channel | dir | transaction
//  --------+-----+-----------------------------------------------------------
//  req     | in  | tick, or load of one task entry (budget, period, offset)
//  rsp     | out | running task, idle flag, miss mask, time, busy/miss totals
//
// A tick goes through accept, a scan of every task entry through the shared
// release/select unit, then emit. A load goes from accept straight to emit.
// Reset clears all entry valid bits, time and counters at once.
// rsp is a registered stage: req is taken again while a result waits there;
// the emit cycle holds only while a previous result is still unread.
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_deadline_tick_scheduler_top #(
	parameter int TASKS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	eds_req_if.sink   req,
	eds_rsp_if.source rsp
);
	import eds_pkg::*;

	localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

	state_t            state_q, state_d;
	ctl_t              ctl;
	logic [IDX_W-1:0]  idx_q, pick_q;
	logic [TIME_W-1:0] time_q, busy_q, miss_q, best_q;
	logic              found_q;
	logic              act_q;
	logic [MASK_W-1:0] mask_q, mask_bit;
	logic              last;

	logic [TASKS-1:0]  valid_q;
	logic [VAL_W-1:0]  budget_q [TASKS];
	logic [VAL_W-1:0]  period_q [TASKS];
	logic [VAL_W-1:0]  work_q   [TASKS];
	logic [TIME_W-1:0] rel_q    [TASKS];
	logic [TIME_W-1:0] due_q    [TASKS];

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_run_q;
	logic              out_idle_q;
	logic [MASK_W-1:0] out_mask_q;
	logic [TIME_W-1:0] out_time_q, out_busy_q, out_miss_q;

	entry_t            ent;
	unit_res_t         res;
	logic              accept, load_ok, ran;
	logic [IDX_W-1:0]  slot_idx;

	assign accept   = ctl.in_ready && req.valid;
	assign load_ok  = (32'(req.task_slot) < TASKS);
	assign slot_idx = IDX_W'(req.task_slot);
	assign last     = (idx_q == IDX_W'(TASKS - 1));
	assign ran      = (act_q == ACT_TICK) && found_q;

	always_comb begin
		ent.valid     = valid_q[idx_q];
		ent.budget    = budget_q[idx_q];
		ent.period    = period_q[idx_q];
		ent.work      = work_q[idx_q];
		ent.release_t = rel_q[idx_q];
		ent.due       = due_q[idx_q];
	end

	always_comb begin
		for (int b = 0; b < MASK_W; b++) begin
			mask_bit[b] = (b < TASKS) && (idx_q == IDX_W'(b));
		end
	end

	eds_unit u_unit (
		.ent      (ent),
		.time_now (time_q),
		.found    (found_q),
		.best     (best_q),
		.res      (res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.action == ACT_LOAD) ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: ctl.in_ready = 1'b1;
			ST_SCAN: ctl.scan     = 1'b1;
			ST_EMIT: ctl.emit     = !out_valid_q || rsp.ready;
			default: ctl          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pick_q      <= '0;
			time_q      <= '0;
			busy_q      <= '0;
			miss_q      <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			act_q       <= ACT_TICK;
			mask_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				act_q   <= req.action;
				idx_q   <= '0;
				found_q <= 1'b0;
				mask_q  <= '0;
				if (req.action == ACT_LOAD && load_ok) begin
					valid_q[slot_idx] <= 1'b1;
				end
			end
			if (ctl.scan) begin
				if (res.miss) begin
					miss_q <= sat_inc(miss_q);
					mask_q <= mask_q | mask_bit;
				end
				if (res.take) begin
					found_q <= 1'b1;
					best_q  <= res.new_due;
					pick_q  <= idx_q;
				end
				if (last) begin
					idx_q <= res.take ? idx_q : pick_q;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
				if (act_q == ACT_TICK) begin
					time_q <= time_q + TIME_W'(1);
				end
				if (ran) begin
					busy_q <= sat_inc(busy_q);
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// task table payload
	always_ff @(posedge clk) begin
		if (accept && req.action == ACT_LOAD && load_ok) begin
			budget_q[slot_idx] <= req.task_budget;
			period_q[slot_idx] <= req.task_period;
			work_q[slot_idx]   <= '0;
			rel_q[slot_idx]    <= TIME_W'(req.task_offset);
			due_q[slot_idx]    <= TIME_W'(req.task_offset) + TIME_W'(req.task_period);
		end else if (ctl.scan && res.rel_hit) begin
			work_q[idx_q] <= ent.budget;
			rel_q[idx_q]  <= res.new_due;
			due_q[idx_q]  <= res.new_due;
		end else if (ctl.emit && ran) begin
			work_q[idx_q] <= ent.work - VAL_W'(1);
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_run_q  <= ran ? SLOT_W'(idx_q) : '0;
			out_idle_q <= !ran;
			out_mask_q <= (act_q == ACT_TICK) ? mask_q : '0;
			out_time_q <= time_q;
			out_busy_q <= ran ? sat_inc(busy_q) : busy_q;
			out_miss_q <= miss_q;
		end
	end

	assign req.ready        = ctl.in_ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.running_task = out_run_q;
	assign rsp.cpu_idle     = out_idle_q;
	assign rsp.miss_mask    = out_mask_q;
	assign rsp.tick_time    = out_time_q;
	assign rsp.busy_ticks   = out_busy_q;
	assign rsp.miss_count   = out_miss_q;

endmodule

`default_nettype wire

// File: src/eds_checker.sv
// ----------------------------------------------------------------------------
// eds_checker
// Port-level checks for the EDF tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_running_task,
	input logic        rsp_cpu_idle,
	input logic [31:0] rsp_tick_time,
	input logic [31:0] rsp_busy_ticks
);

	// one transaction in flight: request side closes after a handshake
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("req ready stayed high after a transaction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(rsp_tick_time) && $stable(rsp_busy_ticks)))
		else $error("rsp payload changed while stalled");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_cpu_idle) |-> (rsp_running_task == 3'd0))
		else $error("idle result names a running task");

	a_busy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_cpu_idle) |-> (rsp_busy_ticks != 32'd0))
		else $error("task ran but busy count is zero");

endmodule

bind earliest_deadline_tick_scheduler_top eds_checker u_eds_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_running_task (rsp.running_task),
	.rsp_cpu_idle     (rsp.cpu_idle),
	.rsp_tick_time    (rsp.tick_time),
	.rsp_busy_ticks   (rsp.busy_ticks)
);

`default_nettype wire
